FILE: rtl/vtrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrq_pkg
// Types and constants shared by the vehicle table radius query block.
// ----------------------------------------------------------------------------
package vtrq_pkg;

	localparam int ID_W  = 32;
	localparam int VAL_W = 24;
	localparam int RAD_W = 23;
	localparam int DIF_W = VAL_W + 1;
	localparam int SQ_W  = 2 * VAL_W;
	localparam int SUM_W = SQ_W + 1;
	localparam int R2_W  = 2 * RAD_W;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd2560;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_FETCH = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_MISS  = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;
	localparam logic [1:0] STS_NO_NB = 2'd3;

	typedef struct packed {
		logic [1:0]              func;
		logic [ID_W-1:0]         vehicle_id;
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] heading;
		logic signed [VAL_W-1:0] vel_x;
		logic signed [VAL_W-1:0] vel_y;
		logic signed [VAL_W-1:0] turn_rate;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [ID_W-1:0]         rec_id;
		logic signed [VAL_W-1:0] rec_x;
		logic signed [VAL_W-1:0] rec_y;
		logic signed [VAL_W-1:0] rec_heading;
		logic signed [VAL_W-1:0] rec_vel_x;
		logic signed [VAL_W-1:0] rec_vel_y;
		logic signed [VAL_W-1:0] rec_turn_rate;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] heading;
		logic signed [VAL_W-1:0] vel_x;
		logic signed [VAL_W-1:0] vel_y;
		logic signed [VAL_W-1:0] turn_rate;
	} rec_t;

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_RAM,
		SRC_PEND
	} out_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MISS,
		ST_NB_RD,
		ST_NB_DIFF,
		ST_NB_SQ,
		ST_NB_CMP,
		ST_NB_END
	} state_t;

	typedef struct packed {
		logic       cap_req;
		logic       idx_clr;
		logic       idx_inc;
		logic       ram_rd;
		logic       ram_wr;
		logic       cnt_inc;
		logic       centre_ld;
		logic       diff_ld;
		logic       sq_ld;
		logic       pend_ld;
		logic       pend_clr;
		logic       out_ld;
		out_src_t   out_src;
		logic [1:0] out_status;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_func;
		logic [1:0] func;
		logic       empty;
		logic       full;
		logic       idx_last;
		logic       id_match;
		logic       centre_found;
		logic       hit;
		logic       pend_valid;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/vtrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module vtrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/vtrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrq_ctrl
// Sequencer for add, fetch and radius query requests.
// ----------------------------------------------------------------------------
module vtrq_ctrl
	import vtrq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (sts.req_func)
						FUNC_ADD:               state_d = ST_ADD;
						FUNC_FETCH, FUNC_QUERY: state_d = sts.empty ? ST_MISS : ST_SCAN_RD;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (sts.func == FUNC_FETCH) begin
					if (sts.id_match) begin
						if (sts.out_free) state_d = ST_IDLE;
					end else if (sts.idx_last) begin
						state_d = ST_MISS;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end else if (sts.idx_last) begin
					state_d = (sts.centre_found || sts.id_match) ? ST_NB_RD : ST_MISS;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MISS: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_NB_RD:   state_d = ST_NB_DIFF;
			ST_NB_DIFF: state_d = ST_NB_SQ;
			ST_NB_SQ:   state_d = ST_NB_CMP;
			ST_NB_CMP: begin
				if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
					state_d = sts.idx_last ? ST_NB_END : ST_NB_RD;
				end
			end
			ST_NB_END: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_src = SRC_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.cap_req  = accept;
				cmd.idx_clr  = accept;
				cmd.pend_clr = accept;
			end
			ST_ADD: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = 1'b1;
					if (sts.full) begin
						cmd.out_status = STS_FULL;
					end else begin
						cmd.ram_wr     = 1'b1;
						cmd.cnt_inc    = 1'b1;
						cmd.out_status = STS_OK;
					end
				end
			end
			ST_SCAN_RD: cmd.ram_rd = 1'b1;
			ST_SCAN_CHK: begin
				if (sts.func == FUNC_FETCH) begin
					if (sts.id_match) begin
						cmd.out_ld     = sts.out_free;
						cmd.out_src    = SRC_RAM;
						cmd.out_status = STS_OK;
						cmd.out_last   = 1'b1;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end else begin
					cmd.centre_ld = sts.id_match;
					cmd.idx_clr   = sts.idx_last;
					cmd.idx_inc   = !sts.idx_last;
				end
			end
			ST_MISS: begin
				cmd.out_ld     = sts.out_free;
				cmd.out_status = STS_MISS;
				cmd.out_last   = 1'b1;
			end
			ST_NB_RD:   cmd.ram_rd  = 1'b1;
			ST_NB_DIFF: cmd.diff_ld = 1'b1;
			ST_NB_SQ:   cmd.sq_ld   = 1'b1;
			ST_NB_CMP: begin
				if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
					cmd.pend_ld    = sts.hit;
					cmd.out_ld     = sts.hit && sts.pend_valid;
					cmd.out_src    = SRC_PEND;
					cmd.out_status = STS_OK;
					cmd.idx_inc    = 1'b1;
				end
			end
			ST_NB_END: begin
				if (sts.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.pend_clr   = 1'b1;
					cmd.out_src    = sts.pend_valid ? SRC_PEND : SRC_NONE;
					cmd.out_status = sts.pend_valid ? STS_OK : STS_NO_NB;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: rtl/vtrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrq_dp
// Record table, distance arithmetic, pending neighbour and response register.
// ----------------------------------------------------------------------------
module vtrq_dp
	import vtrq_pkg::*;
#(
	parameter int MAX_VEHICLES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_wen,
	input  logic [RAD_W-1:0] cfg_wdata,
	input  cmd_t             cmd,
	output sts_t             sts,
	output rsp_t             rsp,
	output logic             rsp_valid,
	input  logic             rsp_ready
);

	localparam int IW = $clog2(MAX_VEHICLES);
	localparam int CW = $clog2(MAX_VEHICLES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VEHICLES);

	req_t                    req_q;
	logic [RAD_W-1:0]        radius_q;
	logic [R2_W-1:0]         r2_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           idx_q;
	logic                    found_q;
	logic signed [VAL_W-1:0] cx_q;
	logic signed [VAL_W-1:0] cy_q;
	logic signed [DIF_W-1:0] dx_q;
	logic signed [DIF_W-1:0] dy_q;
	logic                    id_eq_q;
	rec_t                    cand_q;
	logic [SQ_W-1:0]         sqx_q;
	logic [SQ_W-1:0]         sqy_q;
	logic [SUM_W-1:0]        dist2;
	rec_t                    pend_q;
	logic                    pend_valid_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;
	rec_t                    wr_rec;
	rec_t                    rd_rec;
	rec_t                    out_rec;
	logic [2*DIF_W-1:0]      prod_x;
	logic [2*DIF_W-1:0]      prod_y;
	logic [CW-1:0]           count_m1;

	assign wr_rec = '{id: req_q.vehicle_id, x: req_q.pos_x, y: req_q.pos_y,
		heading: req_q.heading, vel_x: req_q.vel_x, vel_y: req_q.vel_y,
		turn_rate: req_q.turn_rate};

	vtrq_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (MAX_VEHICLES)
	) u_table (
		.clk   (clk),
		.we    (cmd.ram_wr),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_rec),
		.re    (cmd.ram_rd),
		.raddr (idx_q),
		.rdata (rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RESET;
			count_q      <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) radius_q <= cfg_wdata;
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			if (cmd.cap_req) begin
				found_q <= 1'b0;
			end else if (cmd.centre_ld) begin
				found_q <= 1'b1;
			end
			if (cmd.pend_clr) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_ld) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign prod_x = (2*DIF_W)'($signed(dx_q) * $signed(dx_q));
	assign prod_y = (2*DIF_W)'($signed(dy_q) * $signed(dy_q));
	assign dist2  = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_comb begin
		case (cmd.out_src)
			SRC_RAM:  out_rec = rd_rec;
			SRC_PEND: out_rec = pend_q;
			default:  out_rec = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			req_q <= req;
			r2_q  <= R2_W'(radius_q * radius_q);
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.centre_ld) begin
			cx_q <= rd_rec.x;
			cy_q <= rd_rec.y;
		end
		if (cmd.diff_ld) begin
			dx_q    <= DIF_W'(rd_rec.x) - DIF_W'(cx_q);
			dy_q    <= DIF_W'(rd_rec.y) - DIF_W'(cy_q);
			id_eq_q <= (rd_rec.id == req_q.vehicle_id);
			cand_q  <= rd_rec;
		end
		if (cmd.sq_ld) begin
			sqx_q <= prod_x[SQ_W-1:0];
			sqy_q <= prod_y[SQ_W-1:0];
		end
		if (cmd.pend_ld) pend_q <= cand_q;
		if (cmd.out_ld) begin
			rsp_q <= '{status: cmd.out_status, rec_id: out_rec.id, rec_x: out_rec.x,
				rec_y: out_rec.y, rec_heading: out_rec.heading,
				rec_vel_x: out_rec.vel_x, rec_vel_y: out_rec.vel_y,
				rec_turn_rate: out_rec.turn_rate, last: cmd.out_last};
		end
	end

	assign count_m1 = count_q - CW'(1);

	assign sts.req_func     = req.func;
	assign sts.func         = req_q.func;
	assign sts.empty        = (count_q == '0);
	assign sts.full         = (count_q == CNT_MAX);
	assign sts.idx_last     = ({{(CW-IW){1'b0}}, idx_q} == count_m1);
	assign sts.id_match     = (rd_rec.id == req_q.vehicle_id);
	assign sts.centre_found = found_q;
	assign sts.hit          = !id_eq_q && (dist2 <= SUM_W'(r2_q));
	assign sts.pend_valid   = pend_valid_q;
	assign sts.out_free     = !rsp_valid_q || rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: rtl/vehicle_table_radius_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_table_radius_query
// Vehicle record table with add, fetch by identifier and fixed radius query.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   req_valid, req_ready, req        in
//  response  rsp_valid, rsp_ready, rsp        out
//  config    cfg_wen, cfg_wdata (radius)      in
//
//  Add: the request is captured, then the record is written (unless the table is full)
//  and the response loaded. Fetch: each table entry scanned takes a read and a check;
//  a miss adds a miss response. Query: a scan to find the centre, then a neighbour
//  pass (read, difference, square, compare) over every entry and a closing response.
//  Reset clears control, the entry count and sets radius to 10.0; no table clear.
//  A stalled response holds the output register; the neighbour pass halts on a
//  further neighbour while one is pending and the response is stalled.
// ----------------------------------------------------------------------------
module vehicle_table_radius_query
	import vtrq_pkg::*;
#(
	parameter int MAX_VEHICLES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_wen,
	input  logic [RAD_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	vtrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vtrq_dp #(
		.MAX_VEHICLES (MAX_VEHICLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule
